// ----- rtl/ntot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTP offset / time-of-day package
// Field widths, register codes, reset values and the fixed divisors and
// reciprocals used by the time-of-day datapath.
// ----------------------------------------------------------------------------
package ntot_pkg;

   localparam int LOCAL_TIME_W = 63;
   localparam int STAMP_W      = 64;
   localparam int OFFSET_W     = 64;
   localparam int SECS_W       = 40;
   localparam int NTP_EPOCH_W  = 55;
   localparam int LOCAL_EPOCH_W = 57;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 57;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NTP_EPOCH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_EPOCH = 2'd1;

   localparam logic [NTP_EPOCH_W-1:0]   NTP_EPOCH_RESET   = 55'd22089888000000000;
   localparam logic [LOCAL_EPOCH_W-1:0] LOCAL_EPOCH_RESET = 57'd116444736000000000;

   localparam logic [23:0] TICKS_PER_SEC = 24'd10000000;
   // 10^7 = 2^7 * 78125: the low seven bits of a tick count pass straight through
   localparam logic [17:0] SEC_DIVISOR   = 18'd78125;
   localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
   localparam logic [13:0] TICKS_PER_MS  = 14'd10000;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

   // floor(x / d) == (x * R) >> S, exact over the range each one sees
   localparam logic [23:0] MS_RECIP   = 24'd13743896;  // / 10000, shift 37
   localparam logic [15:0] US_RECIP   = 16'd52429;     // / 10,    shift 19
   localparam logic [16:0] HOUR_RECIP = 17'd74566;     // / 3600,  shift 28
   localparam logic [12:0] MIN_RECIP  = 13'd4370;      // / 60,    shift 18

endpackage

// ----- rtl/ntot_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTP offset / time-of-day channels
// Request, response and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface ntot_req_if;
   import ntot_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [LOCAL_TIME_W-1:0]  local_send_time;
   logic [STAMP_W-1:0]       server_receive_stamp;
   logic [STAMP_W-1:0]       server_transmit_stamp;
   logic [LOCAL_TIME_W-1:0]  local_receive_time;
   logic [LOCAL_TIME_W-1:0]  local_current_time;

   modport source (output valid, local_send_time, server_receive_stamp,
                   server_transmit_stamp, local_receive_time, local_current_time,
                   input ready);
   modport sink   (input valid, local_send_time, server_receive_stamp,
                   server_transmit_stamp, local_receive_time, local_current_time,
                   output ready);
endinterface

interface ntot_rsp_if;
   import ntot_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [OFFSET_W-1:0] clock_offset;
   logic [SECS_W-1:0]          unix_seconds;
   logic [4:0]                 hour_of_day;
   logic [5:0]                 minute_of_hour;
   logic [5:0]                 second_of_minute;
   logic [9:0]                 millisecond_part;
   logic [9:0]                 microsecond_part;
   logic                       before_epoch;

   modport source (output valid, clock_offset, unix_seconds, hour_of_day, minute_of_hour,
                   second_of_minute, millisecond_part, microsecond_part, before_epoch,
                   input ready);
   modport sink   (input valid, clock_offset, unix_seconds, hour_of_day, minute_of_hour,
                   second_of_minute, millisecond_part, microsecond_part, before_epoch,
                   output ready);
endinterface

interface ntot_csr_if;
   import ntot_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- rtl/ntp_offset_time_of_day_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTP clock offset and corrected time of day
// Computes the NTP offset from one exchange and splits the corrected clock
// into Unix seconds and UTC hour/minute/second/ms/us.
// ----------------------------------------------------------------------------
// One request is accepted every clock cycle while the response side does not stall;
// each result passes through the sixteen register stages: the seconds division (a
// restoring divider by 78125 retiring eight quotient bits per stage over five
// stages), the seconds-of-day reduction (three more such stages) and the
// hour/minute split (four stages).
// Stalls propagate stage by stage, so empty stages keep taking requests while
// a finished result waits. The two epoch registers reset to the standard
// NTP-to-Unix and local-to-Unix offsets and should be written only while no
// request is in flight.
module ntp_offset_time_of_day_core (
   input logic       clock,
   input logic       reset,
   ntot_req_if.sink   req_bus,
   ntot_rsp_if.source rsp_bus,
   ntot_csr_if.sink   csr_bus
);
   import ntot_pkg::*;

   localparam int STAGES = 16;

   typedef struct packed {
      logic [16:0] rem;
      logic [39:0] quo;
      logic [39:0] dvd;
      logic [6:0]  low;
      logic        neg;
      logic [63:0] offset;
   } div_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [23:0] dvd;
      logic [39:0] secs;
      logic [23:0] tick_rem;
      logic [9:0]  ms;
      logic [13:0] ms_rem;
      logic [9:0]  us;
      logic        neg;
      logic [63:0] offset;
   } mod_type;

   typedef struct packed {
      logic [16:0] sod;
      logic [4:0]  hour;
      logic [11:0] hour_rem;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [39:0] secs;
      logic [9:0]  ms;
      logic [9:0]  us;
      logic        neg;
      logic [63:0] offset;
   } tod_type;

   // eight restoring steps of rem / divisor; returns {rem, quotient byte}
   function automatic logic [24:0] div_step8(logic [16:0] rem_in, logic [7:0] bits_in,
                                             logic [17:0] divisor);
      logic [17:0] acc;
      logic [16:0] rem;
      logic [7:0]  q;
      rem = rem_in;
      q   = '0;
      for (int b = 7; b >= 0; b--) begin
         acc = {rem, bits_in[b]};
         if (acc >= divisor) begin
            acc  = acc - divisor;
            q[b] = 1'b1;
         end
         rem = acc[16:0];
      end
      return {rem, q};
   endfunction

   // ---------------------------------------------------------------- registers
   logic [NTP_EPOCH_W-1:0]   ntp_epoch_ff;
   logic [LOCAL_EPOCH_W-1:0] local_epoch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ntp_epoch_ff   <= NTP_EPOCH_RESET;
         local_epoch_ff <= LOCAL_EPOCH_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_NTP_EPOCH:   ntp_epoch_ff   <= csr_bus.wdata[NTP_EPOCH_W-1:0];
            CSR_LOCAL_EPOCH: local_epoch_ff <= csr_bus.wdata[LOCAL_EPOCH_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // ------------------------------------------------------------ flow control
   logic [STAGES-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_bus.ready;
      for (int i = STAGES-2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign vld_in        = {vld_ff[STAGES-2:0], req_bus.valid};
   assign req_bus.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (en[i]) vld_ff[i] <= vld_in[i];
         end
      end
   end

   // ------------------------------------------- stage 0: stamp scaling, t1/t4
   logic [55:0] s0_rx_sec_ff, s0_tx_sec_ff, s0_rx_sec_in, s0_tx_sec_in;
   logic [23:0] s0_rx_frac_ff, s0_tx_frac_ff, s0_rx_frac_in, s0_tx_frac_in;
   logic [63:0] s0_t1_ff, s0_t4_ff, s0_t1_in, s0_t4_in;
   logic [62:0] s0_cur_ff;

   always_comb begin
      logic [55:0] rx_frac_prod, tx_frac_prod;
      s0_rx_sec_in  = 56'(req_bus.server_receive_stamp[63:32]) * 56'(TICKS_PER_SEC);
      s0_tx_sec_in  = 56'(req_bus.server_transmit_stamp[63:32]) * 56'(TICKS_PER_SEC);
      rx_frac_prod  = 56'(req_bus.server_receive_stamp[31:0]) * 56'(TICKS_PER_SEC);
      tx_frac_prod  = 56'(req_bus.server_transmit_stamp[31:0]) * 56'(TICKS_PER_SEC);
      s0_rx_frac_in = rx_frac_prod[55:32];
      s0_tx_frac_in = tx_frac_prod[55:32];
      s0_t1_in      = 64'(req_bus.local_send_time) - 64'(local_epoch_ff);
      s0_t4_in      = 64'(req_bus.local_receive_time) - 64'(local_epoch_ff);
   end

   // ------------------------------------------------- stage 1: t2, t3, t1+t4
   logic [63:0] s1_t2_ff, s1_t3_ff, s1_t14_ff;
   logic [62:0] s1_cur_ff;

   // ------------------------------------------------------- stage 2: offset
   logic [63:0] s2_offset_ff, s2_diff;
   logic [62:0] s2_cur_ff;

   assign s2_diff = s1_t2_ff + s1_t3_ff - s1_t14_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_rx_sec_ff  <= s0_rx_sec_in;
         s0_tx_sec_ff  <= s0_tx_sec_in;
         s0_rx_frac_ff <= s0_rx_frac_in;
         s0_tx_frac_ff <= s0_tx_frac_in;
         s0_t1_ff      <= s0_t1_in;
         s0_t4_ff      <= s0_t4_in;
         s0_cur_ff     <= req_bus.local_current_time;
      end
      if (en[1]) begin
         s1_t2_ff  <= 64'(s0_rx_sec_ff) + 64'(s0_rx_frac_ff) - 64'(ntp_epoch_ff);
         s1_t3_ff  <= 64'(s0_tx_sec_ff) + 64'(s0_tx_frac_ff) - 64'(ntp_epoch_ff);
         s1_t14_ff <= s0_t1_ff + s0_t4_ff;
         s1_cur_ff <= s0_cur_ff;
      end
      if (en[2]) begin
         s2_offset_ff <= {s2_diff[63], s2_diff[63:1]};
         s2_cur_ff    <= s1_cur_ff;
      end
   end

   // ----------------------------- stages 3..8: corrected time / 10^7 (secs)
   div_type dv_ff [6];
   div_type dv_in [6];

   always_comb begin
      logic [63:0] now;
      logic [24:0] step;
      now = 64'(s2_cur_ff) + s2_offset_ff - 64'(local_epoch_ff);
      // top 16 bits are already below the divisor
      dv_in[0].rem    = {1'b0, now[62:47]};
      dv_in[0].quo    = '0;
      dv_in[0].dvd    = now[46:7];
      dv_in[0].low    = now[6:0];
      dv_in[0].neg    = now[63];
      dv_in[0].offset = s2_offset_ff;
      for (int j = 1; j < 6; j++) begin
         step         = div_step8(dv_ff[j-1].rem, dv_ff[j-1].dvd[39:32], SEC_DIVISOR);
         dv_in[j]     = dv_ff[j-1];
         dv_in[j].rem = step[24:8];
         dv_in[j].quo = {dv_ff[j-1].quo[31:0], step[7:0]};
         dv_in[j].dvd = {dv_ff[j-1].dvd[31:0], 8'b0};
      end
   end

   // --------------------- stages 9..11: secs mod 86400, ms and us in parallel
   mod_type md_ff [3];
   mod_type md_in [3];

   always_comb begin
      logic [24:0] step;
      logic [47:0] ms_prod;
      logic [23:0] ms_back;
      logic [29:0] us_prod;

      step                = div_step8({1'b0, dv_ff[5].quo[39:24]}, dv_ff[5].quo[23:16],
                                      SECS_PER_DAY);
      md_in[0].rem        = step[24:8];
      md_in[0].dvd        = {dv_ff[5].quo[15:0], 8'b0};
      md_in[0].secs       = dv_ff[5].quo;
      md_in[0].tick_rem   = {dv_ff[5].rem, dv_ff[5].low};
      ms_prod             = 48'({dv_ff[5].rem, dv_ff[5].low}) * 48'(MS_RECIP);
      md_in[0].ms         = ms_prod[46:37];
      md_in[0].ms_rem     = '0;
      md_in[0].us         = '0;
      md_in[0].neg        = dv_ff[5].neg;
      md_in[0].offset     = dv_ff[5].offset;

      step                = div_step8(md_ff[0].rem, md_ff[0].dvd[23:16], SECS_PER_DAY);
      md_in[1]            = md_ff[0];
      md_in[1].rem        = step[24:8];
      md_in[1].dvd        = {md_ff[0].dvd[15:0], 8'b0};
      ms_back             = 24'(md_ff[0].ms) * 24'(TICKS_PER_MS);
      md_in[1].ms_rem     = 14'(md_ff[0].tick_rem - ms_back);

      step                = div_step8(md_ff[1].rem, md_ff[1].dvd[23:16], SECS_PER_DAY);
      md_in[2]            = md_ff[1];
      md_in[2].rem        = step[24:8];
      md_in[2].dvd        = {md_ff[1].dvd[15:0], 8'b0};
      us_prod             = 30'(md_ff[1].ms_rem) * 30'(US_RECIP);
      md_in[2].us         = us_prod[28:19];
   end

   // -------------------------------- stages 12..15: hour, minute, second, out
   tod_type td_ff [4];
   tod_type td_in [4];

   always_comb begin
      logic [33:0] hour_prod;
      logic [16:0] hour_back;
      logic [24:0] min_prod;
      logic [11:0] min_back;

      hour_prod         = 34'(md_ff[2].rem) * 34'(HOUR_RECIP);
      td_in[0].sod      = md_ff[2].rem;
      td_in[0].hour     = hour_prod[32:28];
      td_in[0].hour_rem = '0;
      td_in[0].minute   = '0;
      td_in[0].second   = '0;
      td_in[0].secs     = md_ff[2].secs;
      td_in[0].ms       = md_ff[2].ms;
      td_in[0].us       = md_ff[2].us;
      td_in[0].neg      = md_ff[2].neg;
      td_in[0].offset   = md_ff[2].offset;

      hour_back         = 17'(td_ff[0].hour) * 17'(SECS_PER_HOUR);
      td_in[1]          = td_ff[0];
      td_in[1].hour_rem = 12'(td_ff[0].sod - hour_back);

      min_prod          = 25'(td_ff[1].hour_rem) * 25'(MIN_RECIP);
      td_in[2]          = td_ff[1];
      td_in[2].minute   = min_prod[23:18];

      min_back          = 12'(td_ff[2].minute) * 12'(SECS_PER_MIN);
      td_in[3]          = td_ff[2];
      td_in[3].second   = 6'(td_ff[2].hour_rem - min_back);
      // negative corrected time: only the offset and the before-epoch flag survive
      if (td_ff[2].neg) begin
         td_in[3].secs   = '0;
         td_in[3].hour   = '0;
         td_in[3].minute = '0;
         td_in[3].second = '0;
         td_in[3].ms     = '0;
         td_in[3].us     = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 6; j++) begin
         if (en[3+j]) dv_ff[j] <= dv_in[j];
      end
      for (int j = 0; j < 3; j++) begin
         if (en[9+j]) md_ff[j] <= md_in[j];
      end
      for (int j = 0; j < 4; j++) begin
         if (en[12+j]) td_ff[j] <= td_in[j];
      end
   end

   // ------------------------------------------------------------ response
   assign rsp_bus.valid            = vld_ff[STAGES-1];
   assign rsp_bus.clock_offset     = $signed(td_ff[3].offset);
   assign rsp_bus.unix_seconds     = td_ff[3].secs;
   assign rsp_bus.hour_of_day      = td_ff[3].hour;
   assign rsp_bus.minute_of_hour   = td_ff[3].minute;
   assign rsp_bus.second_of_minute = td_ff[3].second;
   assign rsp_bus.millisecond_part = td_ff[3].ms;
   assign rsp_bus.microsecond_part = td_ff[3].us;
   assign rsp_bus.before_epoch     = td_ff[3].neg;

   // ---------------------------------------------------------- assertions
   a_div_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] |-> dv_ff[5].rem < SEC_DIVISOR[16:0])
      else $error("seconds divider remainder out of range");

   a_day_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[11] |-> md_ff[2].rem < SECS_PER_DAY[16:0])
      else $error("seconds-of-day remainder out of range");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1] |-> (td_ff[3].hour < 5'd24) && (td_ff[3].minute < 6'd60) &&
                           (td_ff[3].second < 6'd60) && (td_ff[3].ms < 10'd1000) &&
                           (td_ff[3].us < 10'd1000))
      else $error("time-of-day field out of range");

   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && td_ff[3].neg) |-> (td_ff[3].secs == '0) && (td_ff[3].ms == '0))
      else $error("time fields not cleared before epoch");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not flushed by reset");

endmodule
